>>> hdl/rss_pkg.sv
// package for the record selection sort block: word types, field widths and state codes
package rss_pkg;

    localparam int KEY_W   = 64;
    localparam int IDX_W   = 2;
    localparam int CODE_W  = 32;
    localparam int PRICE_W = 32;

    typedef struct packed {
        logic [KEY_W-1:0]          key_chunk;
        logic [IDX_W-1:0]          chunk_index;
        logic signed [CODE_W-1:0]  item_code;
        logic [PRICE_W-1:0]        price_bits;
        logic                      last_record;
    } t_in_word;

    typedef struct packed {
        logic [KEY_W-1:0]          out_key_chunk;
        logic [IDX_W-1:0]          out_chunk_index;
        logic signed [CODE_W-1:0]  out_code;
        logic [PRICE_W-1:0]        out_price_bits;
        logic                      out_last;
    } t_out_word;

    typedef struct packed {
        logic signed [CODE_W-1:0]  code;
        logic [PRICE_W-1:0]        price;
    } t_meta;

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_SCAN,
        S_WAIT,
        S_SWAP,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RD_INIT,
        RD_SCAN,
        RD_EMIT
    } t_rd_mode;

endpackage

>>> hdl/record_selection_sort.sv
// record selection sort: key and code/price memories with a read-compare-swap sequencer
//
// Records arrive as KEY_CHUNKS key words each, one word accepted per cycle while
// loading; the final chunk of a record carries its code and price and commits it,
// and a final chunk with last_record set starts the sort. Keys, codes and prices
// live in two single-port-read memories with registered reads, and one sequencer
// walks them: pass i reads record i, reads every later record chunk by chunk
// against the running minimum, waits in S_WAIT and writes the swap back, first
// the minimum into row i, then the old record i into the minimum's row. Results
// then leave one word at a time when the sink is ready; a new result word is read
// only once the previous read has landed and the output register is free or being
// taken. Input is held off from the sort trigger until the last result word has
// been read from memory.
module record_selection_sort #(
    parameter int RECORDS    = 16,
    parameter int KEY_CHUNKS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rss_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output rss_pkg::t_out_word o_data
);
    import rss_pkg::*;

    localparam int RW    = $clog2(RECORDS);
    localparam int CW    = $clog2(RECORDS + 1);
    localparam int CHW   = (KEY_CHUNKS > 1) ? $clog2(KEY_CHUNKS) : 1;
    localparam int DEPTH = RECORDS * KEY_CHUNKS;
    localparam int KAW   = $clog2(DEPTH);
    localparam logic [CHW-1:0] LAST_C = CHW'(KEY_CHUNKS - 1);
    localparam logic [CW-1:0]  FULL   = CW'(RECORDS);

    function automatic logic [KAW-1:0] f_addr(input logic [RW-1:0] row,
                                              input logic [CHW-1:0] c);
        return KAW'(row) * KAW'(KEY_CHUNKS) + KAW'(c);
    endfunction

    logic [KEY_W-1:0] r_key_mem [DEPTH];
    t_meta            r_meta_mem [RECORDS];

    t_state           r_state, n_state;
    logic [RW-1:0]    r_i, n_i;
    logic [RW-1:0]    r_j, n_j;
    logic [CW-1:0]    r_n, n_n;
    logic [CW-1:0]    r_count, n_count;
    logic [CHW-1:0]   r_iss_c, n_iss_c;
    logic             r_sw_ph, n_sw_ph;

    logic             w_iss;
    t_rd_mode         w_iss_mode;
    logic [RW-1:0]    w_iss_row;
    logic             w_iss_end;
    logic             w_iss_last;

    logic             r_rd_vld;
    t_rd_mode         r_rd_mode;
    logic [RW-1:0]    r_rd_row;
    logic [CHW-1:0]   r_rd_c;
    logic             r_rd_end;
    logic             r_rd_last;

    logic             w_key_we;
    logic [KAW-1:0]   w_key_wa;
    logic [KEY_W-1:0] w_key_wd;
    logic [KAW-1:0]   w_key_ra;
    logic [KEY_W-1:0] r_key_rd;
    logic             w_meta_we;
    logic [RW-1:0]    w_meta_wa;
    t_meta            w_meta_wd;
    t_meta            r_meta_rd;

    logic [KEY_W-1:0] r_cur_key  [KEY_CHUNKS];
    logic [KEY_W-1:0] r_best_key [KEY_CHUNKS];
    logic [KEY_W-1:0] r_cand_key [KEY_CHUNKS];
    t_meta            r_cur_meta;
    t_meta            r_best_meta;
    logic [RW-1:0]    r_best;
    logic             r_dec;
    logic             r_lt;

    logic             r_out_vld;
    t_out_word        r_out;

    logic             w_in_acc;
    logic             w_idx_ok;
    logic             w_final;
    logic             w_room;
    logic             w_out_take;
    logic             w_dec_in;
    logic             w_dec;
    logic             w_lt;

    assign o_ready    = (r_state == S_LOAD);
    assign o_valid    = r_out_vld;
    assign o_data     = r_out;
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_take = r_out_vld && i_ready;
    assign w_idx_ok   = ({1'b0, i_data.chunk_index} < 3'(KEY_CHUNKS));
    assign w_final    = w_idx_ok && (i_data.chunk_index == IDX_W'(KEY_CHUNKS - 1));
    assign w_room     = (r_count < FULL);
    assign w_key_ra   = f_addr(w_iss_row, r_iss_c);

    // running lexicographic compare of the scanned record against the minimum
    assign w_dec_in = (r_rd_c != '0) && r_dec;
    assign w_dec    = w_dec_in || (r_key_rd != r_best_key[r_rd_c]);
    assign w_lt     = w_dec_in ? r_lt : (r_key_rd < r_best_key[r_rd_c]);

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_n        = r_n;
        n_count    = r_count;
        n_iss_c    = r_iss_c;
        n_sw_ph    = r_sw_ph;
        w_iss      = 1'b0;
        w_iss_mode = RD_INIT;
        w_iss_row  = r_i;
        w_iss_end  = (r_iss_c == LAST_C);
        w_iss_last = 1'b0;
        w_key_we   = 1'b0;
        w_key_wa   = f_addr(r_count[RW-1:0], CHW'(i_data.chunk_index));
        w_key_wd   = i_data.key_chunk;
        w_meta_we  = 1'b0;
        w_meta_wa  = r_count[RW-1:0];
        w_meta_wd  = '{code: i_data.item_code, price: i_data.price_bits};
        case (r_state)
            S_LOAD: begin
                if (w_in_acc && w_idx_ok) begin
                    if (w_room) begin
                        w_key_we = 1'b1;
                        if (w_final) begin
                            w_meta_we = 1'b1;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    if (w_final && i_data.last_record) begin
                        n_n     = n_count;
                        n_count = '0;
                        n_i     = '0;
                        n_j     = '0;
                        n_iss_c = '0;
                        if (n_n == CW'(1)) begin
                            n_state = S_EMIT;
                        end else if (n_n != '0) begin
                            n_state = S_INIT;
                        end
                    end
                end
            end
            S_INIT: begin
                w_iss      = 1'b1;
                w_iss_mode = RD_INIT;
                w_iss_row  = r_i;
                if (w_iss_end) begin
                    n_iss_c = '0;
                    n_j     = r_i + RW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_iss_c = r_iss_c + CHW'(1);
                end
            end
            S_SCAN: begin
                w_iss      = 1'b1;
                w_iss_mode = RD_SCAN;
                w_iss_row  = r_j;
                if (w_iss_end) begin
                    n_iss_c = '0;
                    if (CW'(r_j) + CW'(1) == r_n) begin
                        n_state = S_WAIT;
                    end else begin
                        n_j = r_j + RW'(1);
                    end
                end else begin
                    n_iss_c = r_iss_c + CHW'(1);
                end
            end
            S_WAIT: begin
                n_iss_c = '0;
                n_sw_ph = 1'b0;
                n_state = S_SWAP;
            end
            S_SWAP: begin
                w_key_we  = 1'b1;
                w_meta_we = (r_iss_c == '0);
                if (!r_sw_ph) begin
                    w_key_wa  = f_addr(r_i, r_iss_c);
                    w_key_wd  = r_best_key[r_iss_c];
                    w_meta_wa = r_i;
                    w_meta_wd = r_best_meta;
                end else begin
                    w_key_wa  = f_addr(r_best, r_iss_c);
                    w_key_wd  = r_cur_key[r_iss_c];
                    w_meta_wa = r_best;
                    w_meta_wd = r_cur_meta;
                end
                if (w_iss_end) begin
                    n_iss_c = '0;
                    if (r_sw_ph) begin
                        n_sw_ph = 1'b0;
                        n_i     = r_i + RW'(1);
                        if (CW'(r_i) + CW'(2) == r_n) begin
                            n_j     = '0;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_INIT;
                        end
                    end else begin
                        n_sw_ph = 1'b1;
                    end
                end else begin
                    n_iss_c = r_iss_c + CHW'(1);
                end
            end
            S_EMIT: begin
                w_iss_mode = RD_EMIT;
                w_iss_row  = r_j;
                w_iss_last = w_iss_end && (CW'(r_j) + CW'(1) == r_n);
                if (!r_rd_vld && (!r_out_vld || i_ready)) begin
                    w_iss = 1'b1;
                    if (w_iss_end) begin
                        n_iss_c = '0;
                        if (CW'(r_j) + CW'(1) == r_n) begin
                            n_state = S_LOAD;
                        end else begin
                            n_j = r_j + RW'(1);
                        end
                    end else begin
                        n_iss_c = r_iss_c + CHW'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_i       <= '0;
            r_j       <= '0;
            r_n       <= '0;
            r_count   <= '0;
            r_iss_c   <= '0;
            r_sw_ph   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_mode <= RD_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_j       <= n_j;
            r_n       <= n_n;
            r_count   <= n_count;
            r_iss_c   <= n_iss_c;
            r_sw_ph   <= n_sw_ph;
            r_rd_vld  <= w_iss;
            r_rd_mode <= w_iss_mode;
            if (r_rd_vld && (r_rd_mode == RD_EMIT)) begin
                r_out_vld <= 1'b1;
            end else if (w_out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_key_wa] <= w_key_wd;
        end
        if (w_meta_we) begin
            r_meta_mem[w_meta_wa] <= w_meta_wd;
        end
        r_key_rd  <= r_key_mem[w_key_ra];
        r_meta_rd <= r_meta_mem[w_iss_row];
    end

    // read tag and datapath
    always_ff @(posedge i_clk) begin
        r_rd_row  <= w_iss_row;
        r_rd_c    <= r_iss_c;
        r_rd_end  <= w_iss_end;
        r_rd_last <= w_iss_last;
        if (r_rd_vld) begin
            case (r_rd_mode)
                RD_INIT: begin
                    r_cur_key[r_rd_c]  <= r_key_rd;
                    r_best_key[r_rd_c] <= r_key_rd;
                    r_cur_meta         <= r_meta_rd;
                    r_best_meta        <= r_meta_rd;
                    r_best             <= r_rd_row;
                end
                RD_SCAN: begin
                    r_cand_key[r_rd_c] <= r_key_rd;
                    r_dec              <= w_dec;
                    r_lt               <= w_lt;
                    if (r_rd_end && w_lt) begin
                        for (int k = 0; k < KEY_CHUNKS; k++) begin
                            r_best_key[k] <= (CHW'(k) == r_rd_c) ? r_key_rd : r_cand_key[k];
                        end
                        r_best_meta <= r_meta_rd;
                        r_best      <= r_rd_row;
                    end
                end
                RD_EMIT: begin
                    r_out.out_key_chunk   <= r_key_rd;
                    r_out.out_chunk_index <= IDX_W'(r_rd_c);
                    r_out.out_code        <= r_meta_rd.code;
                    r_out.out_price_bits  <= r_meta_rd.price;
                    r_out.out_last        <= r_rd_last;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> test/tb.sv
// testbench for record_selection_sort: predicts sorted record words and checks every output word
`timescale 1ns / 1ps

module tb;
    import rss_pkg::*;

    localparam int RECORDS    = 16;
    localparam int KEY_CHUNKS = 4;
    localparam int SLOTS      = RECORDS * KEY_CHUNKS;

    typedef logic [KEY_CHUNKS*KEY_W-1:0] t_key;

    typedef enum int {
        REC_PLAIN,
        REC_SKIP,
        REC_REPEAT,
        REC_SHUFFLE,
        REC_EARLY_LAST
    } t_rec_mode;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_ready = 1'b0;
    t_in_word   i_data  = '0;
    logic       o_ready;
    logic       o_valid;
    t_out_word  o_data;

    logic [KEY_W-1:0]   key_mem   [SLOTS];
    logic [CODE_W-1:0]  code_mem  [RECORDS];
    logic [PRICE_W-1:0] price_mem [RECORDS];
    bit                 key_seen  [SLOTS];
    int                 stored_cnt = 0;

    t_out_word sorted_q [$];
    t_key      key_pool [$];
    int        fail_cnt     = 0;
    int        items_sent   = 0;
    bit        src_idle_on  = 1'b1;
    bit        sink_stall_on = 1'b1;

    record_selection_sort #(
        .RECORDS    (RECORDS),
        .KEY_CHUNKS (KEY_CHUNKS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    // store one accepted word; a final chunk with last_record sorts and queues every record
    task automatic absorb_word(input t_in_word w);
        int                 n;
        int                 best;
        int                 slot;
        bit                 less;
        bit                 decided;
        logic [KEY_W-1:0]   tk;
        logic [CODE_W-1:0]  t32;
        t_out_word          o;
        if (w.chunk_index >= KEY_CHUNKS) return;
        if (stored_cnt < RECORDS) begin
            slot = stored_cnt * KEY_CHUNKS + w.chunk_index;
            key_mem[slot]  = w.key_chunk;
            key_seen[slot] = 1'b1;
            if (w.chunk_index == KEY_CHUNKS - 1) begin
                code_mem[stored_cnt]  = w.item_code;
                price_mem[stored_cnt] = w.price_bits;
                stored_cnt++;
            end
        end
        if (!(w.last_record && w.chunk_index == KEY_CHUNKS - 1)) return;
        n = stored_cnt;
        for (int i = 0; i + 1 < n; i++) begin
            best = i;
            for (int j = i + 1; j < n; j++) begin
                decided = 1'b0;
                less    = 1'b0;
                for (int c = 0; c < KEY_CHUNKS && !decided; c++) begin
                    if (key_mem[j*KEY_CHUNKS+c] != key_mem[best*KEY_CHUNKS+c]) begin
                        decided = 1'b1;
                        less    = key_mem[j*KEY_CHUNKS+c] < key_mem[best*KEY_CHUNKS+c];
                    end
                end
                if (less) best = j;
            end
            for (int c = 0; c < KEY_CHUNKS; c++) begin
                tk = key_mem[best*KEY_CHUNKS+c];
                key_mem[best*KEY_CHUNKS+c] = key_mem[i*KEY_CHUNKS+c];
                key_mem[i*KEY_CHUNKS+c]    = tk;
            end
            t32 = code_mem[best];  code_mem[best]  = code_mem[i];  code_mem[i]  = t32;
            t32 = price_mem[best]; price_mem[best] = price_mem[i]; price_mem[i] = t32;
        end
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < KEY_CHUNKS; c++) begin
                o.out_key_chunk   = key_mem[r*KEY_CHUNKS+c];
                o.out_chunk_index = c[IDX_W-1:0];
                o.out_code        = code_mem[r];
                o.out_price_bits  = price_mem[r];
                o.out_last        = (r == n - 1) && (c == KEY_CHUNKS - 1);
                sorted_q.push_back(o);
            end
        end
        stored_cnt = 0;
    endtask

    task automatic send_word(input t_in_word w);
        if (src_idle_on) begin
            while ($urandom_range(0, 99) < 34) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        absorb_word(w);
    endtask

    task automatic send_record(input t_key key, input logic [CODE_W-1:0] code,
                               input logic [PRICE_W-1:0] price, input logic last,
                               input t_rec_mode mode);
        t_in_word w;
        int       c;
        int       base;
        base          = stored_cnt * KEY_CHUNKS;
        w.item_code   = code;
        w.price_bits  = price;
        w.last_record = (mode == REC_EARLY_LAST);
        if (mode == REC_REPEAT) begin
            w.chunk_index = '0;
            w.key_chunk   = {$urandom, $urandom};
            send_word(w);
        end
        for (int i = 0; i < KEY_CHUNKS - 1; i++) begin
            c = (mode == REC_SHUFFLE) ? KEY_CHUNKS - 2 - i : i;
            // a skipped slot must already hold a written chunk
            if (mode == REC_SKIP && c == KEY_CHUNKS - 2 && stored_cnt < RECORDS
                && key_seen[base+c]) continue;
            w.chunk_index = c[IDX_W-1:0];
            w.key_chunk   = key[(KEY_CHUNKS-1-c)*KEY_W +: KEY_W];
            send_word(w);
        end
        w.chunk_index = IDX_W'(KEY_CHUNKS - 1);
        w.key_chunk   = key[KEY_W-1:0];
        w.last_record = last;
        send_word(w);
    endtask

    function automatic t_key make_key();
        t_key k;
        int   len;
        k = '0;
        if ($urandom_range(0, 9) == 0) begin
            for (int c = 0; c < KEY_CHUNKS; c++) k[c*KEY_W +: KEY_W] = {$urandom, $urandom};
            return k;
        end
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 30)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        len = $urandom_range(0, KEY_CHUNKS * 8);
        for (int b = 0; b < len; b++)
            k[KEY_CHUNKS*KEY_W-1-8*b -: 8] = ($urandom_range(0, 99) < 90) ?
                8'("A" + $urandom_range(0, 3)) : 8'($urandom_range(1, 255));
        key_pool.push_back(k);
        return k;
    endfunction

    task automatic report_field(input string name, input logic [63:0] want_v,
                                input logic [63:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected output word, expected none, got %h", $time, o_data);
                fail_cnt++;
            end else begin
                want = sorted_q.pop_front();
                report_field("key chunk", want.out_key_chunk, o_data.out_key_chunk);
                report_field("chunk index", 64'(want.out_chunk_index),
                             64'(o_data.out_chunk_index));
                report_field("code", 64'(want.out_code), 64'(o_data.out_code));
                report_field("price", 64'(want.out_price_bits), 64'(o_data.out_price_bits));
                report_field("last", 64'(want.out_last), 64'(o_data.out_last));
            end
        end
        i_ready <= sink_stall_on ? ($urandom_range(0, 99) >= 34) : 1'b1;
    end

    task automatic test_extremes();
        send_record('1, 32'sh7FFF_FFFF, '1, 1'b0, REC_EARLY_LAST);
        send_record('0, 32'sh8000_0000, '0, 1'b1, REC_PLAIN);
    endtask

    // equal keys: the swap puts later ties ahead of earlier ones
    task automatic test_equal_keys();
        send_record({"BETA", {(KEY_CHUNKS*KEY_W-32){1'b0}}}, 1, 32'h1111_1111, 1'b0, REC_SKIP);
        send_record({"BETA", {(KEY_CHUNKS*KEY_W-32){1'b0}}}, 2, 32'h2222_2222, 1'b0, REC_PLAIN);
        send_record({"ALFA", {(KEY_CHUNKS*KEY_W-32){1'b0}}}, 3, 32'h3333_3333, 1'b1, REC_REPEAT);
    endtask

    task automatic test_store_full();
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
        for (int r = 0; r <= RECORDS; r++)
            send_record(make_key(), $urandom, $urandom, r == RECORDS, REC_PLAIN);
        i_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
        src_idle_on   = 1'b1;
        sink_stall_on = 1'b1;
    endtask

    task automatic test_random_batches();
        int        start;
        int        n;
        t_rec_mode mode;
        t_in_word  w;
        start = items_sent;
        while (items_sent - start < 70) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(RECORDS - 2, RECORDS + 2)
                                            : $urandom_range(1, 5);
            for (int r = 0; r < n; r++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // stray non-final chunk
                    w.key_chunk   = {$urandom, $urandom};
                    w.chunk_index = IDX_W'($urandom_range(0, KEY_CHUNKS - 2));
                    w.item_code   = $urandom;
                    w.price_bits  = $urandom;
                    w.last_record = 1'($urandom_range(0, 1));
                    send_word(w);
                end
                mode = ($urandom_range(0, 99) < 70) ? REC_PLAIN
                                                    : t_rec_mode'($urandom_range(1, 4));
                send_record(make_key(), $urandom, $urandom, r == n - 1, mode);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_equal_keys();
        test_store_full();
        test_random_batches();
        i_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && sorted_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("%0t: timeout with %0d words outstanding", $time, sorted_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
hdl/rss_pkg.sv
hdl/record_selection_sort.sv
test/tb.sv
